>>> sv/mesic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mesic_pkg
// Shared types and codes of the two-way MESI snooping cache.
// ----------------------------------------------------------------------------
package mesic_pkg;

    localparam int TAG_BITS  = 24;
    localparam int SET_BITS  = 4;
    localparam int OFF_BITS  = 4;
    localparam int WORD_BITS = 32;
    localparam int SET_LO    = OFF_BITS;
    localparam int TAG_LO    = 32 - TAG_BITS;
    localparam int DADDR_BITS = 1 + SET_BITS + OFF_BITS;

    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_SREAD = 3'd3;
    localparam logic [2:0] CMD_SINV  = 3'd4;
    localparam logic [2:0] CMD_SRWIM = 3'd5;

    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WDONE = 3'd1;
    localparam logic [2:0] KIND_MISS  = 3'd2;
    localparam logic [2:0] KIND_FILL  = 3'd3;
    localparam logic [2:0] KIND_SWORD = 3'd4;
    localparam logic [2:0] KIND_SMISS = 3'd5;
    localparam logic [2:0] KIND_BUSY  = 3'd6;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_INV   = 3'd2;
    localparam logic [2:0] OP_RWITM = 3'd3;
    localparam logic [2:0] OP_WB    = 3'd4;

    localparam logic [1:0] ST_I = 2'b00;
    localparam logic [1:0] ST_S = 2'b01;
    localparam logic [1:0] ST_M = 2'b10;
    localparam logic [1:0] ST_E = 2'b11;

    typedef struct packed {
        logic [1:0]          st;
        logic [TAG_BITS-1:0] tag;
    } t_tag_ent;

    typedef t_tag_ent [1:0] t_tag_row;

endpackage
`default_nettype wire

>>> sv/mesic_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mesic_ram
// Line word memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mesic_ram (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [mesic_pkg::DADDR_BITS-1:0]     i_waddr,
    input  wire logic [mesic_pkg::WORD_BITS-1:0]      i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [mesic_pkg::DADDR_BITS-1:0]     i_raddr,
    output logic      [mesic_pkg::WORD_BITS-1:0]      o_rdata
);
    logic [mesic_pkg::WORD_BITS-1:0] mem [2**mesic_pkg::DADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> sv/two_way_mesi_snooping_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_way_mesi_snooping_cache
// Two-way set-associative MESI cache serving CPU accesses, fills and snoops.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes the line and tag memories; no item is
// accepted meanwhile. One item is handled at a time: the tag row is read when
// the item is accepted and rewritten in the tag state. A cpu read hit or a final
// fill word also reads a line word from memory, and a snoop that supplies a line
// sends its 16 words, one word per cycle while the output is not stalled, from the
// single read port of the line memory. A stalled output holds the engine.
module two_way_mesi_snooping_cache (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,   // address[31:0], data[63:32]
    input  wire logic [3:0]  i_s_tuser,   // cmd[2:0], from_cache[3]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [39:0] o_m_tdata,   // data_out[31:0], bus_op[34:32], word_index[38:35]
    output logic      [2:0]  o_m_tuser,   // kind[2:0]
    output logic             o_m_tlast
);
    localparam int SB = mesic_pkg::SET_BITS;
    localparam int OB = mesic_pkg::OFF_BITS;
    localparam int AB = mesic_pkg::DADDR_BITS;
    localparam int WB = mesic_pkg::WORD_BITS;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_TAG  = 6'b000100,
        S_FRD  = 6'b001000,
        S_DATA = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [AB-1:0] r_clr, n_clr;
    logic [2:0]  r_cmd;
    logic [31:0] r_addr;
    logic [WB-1:0] r_data;
    logic        r_fc;
    logic [SB-1:0] r_rset;
    logic        r_lru, n_lru;
    logic        r_fbusy, n_fbusy;
    logic [OB-1:0] r_fcnt, n_fcnt;
    logic [31:0] r_faddr, n_faddr;
    logic        r_fsh, n_fsh;
    logic [OB-1:0] r_cnt, n_cnt;
    logic        r_eway, n_eway;
    logic [2:0]  r_eop, n_eop;
    logic        r_ov, n_ov;
    logic [2:0]  r_okind, n_okind;
    logic [WB-1:0] r_odata, n_odata;
    logic [2:0]  r_oop, n_oop;
    logic [OB-1:0] r_owi, n_owi;
    logic        r_olast, n_olast;

    mesic_pkg::t_tag_row tag_mem [2**SB];
    mesic_pkg::t_tag_row r_trow, tw_row;
    logic          tw_en;
    logic [SB-1:0] tw_set;
    logic          tr_en;
    logic [SB-1:0] tr_set;

    logic          dw_en, rd_en;
    logic [AB-1:0] dw_addr, rd_addr;
    logic [WB-1:0] dw_data, dq;

    logic accept, out_free, hit0, hit1, hit, w, victim, sh;
    logic [SB-1:0] set_a, fset;
    logic [OB-1:0] off_a, foff;
    logic [mesic_pkg::TAG_BITS-1:0] tag_a;
    mesic_pkg::t_tag_ent ent_w;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_ov || i_m_tready;
    assign set_a  = r_addr[mesic_pkg::SET_LO +: SB];
    assign off_a  = r_addr[OB-1:0];
    assign tag_a  = r_addr[31:mesic_pkg::TAG_LO];
    assign fset   = r_faddr[mesic_pkg::SET_LO +: SB];
    assign foff   = r_faddr[OB-1:0];
    assign hit0   = r_trow[0].st != mesic_pkg::ST_I && r_trow[0].tag == tag_a;
    assign hit1   = r_trow[1].st != mesic_pkg::ST_I && r_trow[1].tag == tag_a;
    assign hit    = hit0 || hit1;
    assign w      = !hit0;
    assign ent_w  = r_trow[w];
    assign victim = !r_lru;
    assign sh     = r_fsh || r_fc;

    assign tr_en  = accept;
    assign tr_set = (i_s_tuser[2:0] == mesic_pkg::CMD_FILL) ? fset
                  : i_s_tdata[mesic_pkg::SET_LO +: SB];

    mesic_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (dw_en),
        .i_waddr (dw_addr),
        .i_wdata (dw_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (dq)
    );

    always_ff @(posedge i_clk) begin
        if (tw_en) begin
            tag_mem[tw_set] <= tw_row;
        end
        if (tr_en) begin
            r_trow <= tag_mem[tr_set];
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_lru   = r_lru;
        n_fbusy = r_fbusy;
        n_fcnt  = r_fcnt;
        n_faddr = r_faddr;
        n_fsh   = r_fsh;
        n_cnt   = r_cnt;
        n_eway  = r_eway;
        n_eop   = r_eop;
        n_ov    = r_ov && !i_m_tready;
        n_okind = r_okind;
        n_odata = r_odata;
        n_oop   = r_oop;
        n_owi   = r_owi;
        n_olast = r_olast;
        tw_en   = 1'b0;
        tw_set  = r_rset;
        tw_row  = r_trow;
        dw_en   = 1'b0;
        dw_addr = {w, set_a, off_a};
        dw_data = r_data;
        rd_en   = 1'b0;
        rd_addr = {w, set_a, off_a};

        unique case (r_state)
            S_CLR: begin
                dw_en   = 1'b1;
                dw_addr = r_clr;
                dw_data = '0;
                tw_en   = 1'b1;
                tw_set  = r_clr[SB-1:0];
                tw_row  = '0;
                n_clr   = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_TAG;
                end
            end
            S_TAG: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_ov    = 1'b1;
                    n_okind = mesic_pkg::KIND_SMISS;
                    n_odata = '0;
                    n_oop   = mesic_pkg::OP_NONE;
                    n_owi   = '0;
                    n_olast = 1'b1;
                    priority if ((r_cmd == mesic_pkg::CMD_READ ||
                                  r_cmd == mesic_pkg::CMD_WRITE) && r_fbusy) begin
                        n_okind = mesic_pkg::KIND_BUSY;
                    end else if (r_cmd == mesic_pkg::CMD_READ) begin
                        if (hit) begin
                            n_ov    = r_ov && !i_m_tready;
                            n_lru   = w;
                            rd_en   = 1'b1;
                            n_state = S_DATA;
                        end else begin
                            tw_en          = 1'b1;
                            tw_row[victim] = '0;
                            n_fbusy = 1'b1;
                            n_fcnt  = '0;
                            n_faddr = r_addr;
                            n_fsh   = 1'b0;
                            n_okind = mesic_pkg::KIND_MISS;
                            n_oop   = mesic_pkg::OP_READ;
                        end
                    end else if (r_cmd == mesic_pkg::CMD_WRITE) begin
                        tw_en = 1'b1;
                        dw_en = 1'b1;
                        if (hit) begin
                            tw_row[w] = '{st: mesic_pkg::ST_M, tag: tag_a};
                            n_lru     = w;
                            n_oop     = (ent_w.st == mesic_pkg::ST_S) ? mesic_pkg::OP_INV
                                                                      : mesic_pkg::OP_NONE;
                        end else begin
                            tw_row[victim] = '{st: mesic_pkg::ST_M, tag: tag_a};
                            dw_addr        = {victim, set_a, off_a};
                            n_lru          = victim;
                            n_oop          = mesic_pkg::OP_RWITM;
                        end
                        n_okind = mesic_pkg::KIND_WDONE;
                        n_owi   = off_a;
                    end else if (r_cmd == mesic_pkg::CMD_FILL) begin
                        n_ov = r_ov && !i_m_tready;
                        if (r_fbusy) begin
                            dw_en   = 1'b1;
                            dw_addr = {victim, fset, r_fcnt};
                            n_fcnt  = r_fcnt + 1'b1;
                            if (&r_fcnt) begin
                                tw_en          = 1'b1;
                                tw_row[victim] = '{st: sh ? mesic_pkg::ST_S : mesic_pkg::ST_E,
                                                   tag: r_faddr[31:mesic_pkg::TAG_LO]};
                                n_lru   = victim;
                                n_fbusy = 1'b0;
                                n_fsh   = 1'b0;
                                n_state = S_FRD;
                            end else begin
                                n_fsh   = sh;
                                n_ov    = 1'b1;
                                n_okind = mesic_pkg::KIND_FILL;
                                n_odata = r_data;
                                n_owi   = r_fcnt;
                            end
                        end
                    end else if (r_cmd == mesic_pkg::CMD_SREAD) begin
                        if (hit) begin
                            tw_en     = 1'b1;
                            tw_row[w] = '{st: mesic_pkg::ST_S, tag: tag_a};
                            n_ov      = r_ov && !i_m_tready;
                            n_eway    = w;
                            n_eop     = (ent_w.st == mesic_pkg::ST_M) ? mesic_pkg::OP_WB
                                                                      : mesic_pkg::OP_NONE;
                            n_cnt     = '0;
                            rd_en     = 1'b1;
                            rd_addr   = {w, set_a, {OB{1'b0}}};
                            n_state   = S_EMIT;
                        end
                    end else if (r_cmd == mesic_pkg::CMD_SINV) begin
                        if (hit && ent_w.st == mesic_pkg::ST_S) begin
                            tw_en     = 1'b1;
                            tw_row[w] = '{st: mesic_pkg::ST_I, tag: tag_a};
                        end
                    end else if (r_cmd == mesic_pkg::CMD_SRWIM) begin
                        if (hit) begin
                            tw_en     = 1'b1;
                            tw_row[w] = '{st: mesic_pkg::ST_I, tag: tag_a};
                            if (ent_w.st == mesic_pkg::ST_M) begin
                                n_ov    = r_ov && !i_m_tready;
                                n_eway  = w;
                                n_eop   = mesic_pkg::OP_WB;
                                n_cnt   = '0;
                                rd_en   = 1'b1;
                                rd_addr = {w, set_a, {OB{1'b0}}};
                                n_state = S_EMIT;
                            end
                        end
                    end else begin
                        n_ov = r_ov && !i_m_tready;
                    end
                end
            end
            S_FRD: begin
                rd_en   = 1'b1;
                rd_addr = {r_lru, fset, foff};
                n_state = S_DATA;
            end
            S_DATA: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = (r_cmd == mesic_pkg::CMD_READ) ? mesic_pkg::KIND_READ
                                                             : mesic_pkg::KIND_FILL;
                    n_odata = dq;
                    n_oop   = mesic_pkg::OP_NONE;
                    n_owi   = (r_cmd == mesic_pkg::CMD_READ) ? off_a : foff;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = mesic_pkg::KIND_SWORD;
                    n_odata = dq;
                    n_oop   = r_eop;
                    n_owi   = r_cnt;
                    n_olast = &r_cnt;
                    if (&r_cnt) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = {r_eway, set_a, r_cnt + 1'b1};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_lru   <= 1'b0;
            r_fbusy <= 1'b0;
            r_fcnt  <= '0;
            r_faddr <= '0;
            r_fsh   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_lru   <= n_lru;
            r_fbusy <= n_fbusy;
            r_fcnt  <= n_fcnt;
            r_faddr <= n_faddr;
            r_fsh   <= n_fsh;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_s_tuser[2:0];
            r_fc   <= i_s_tuser[3];
            r_addr <= i_s_tdata[31:0];
            r_data <= i_s_tdata[32 +: WB];
            r_rset <= tr_set;
        end
        r_cnt   <= n_cnt;
        r_eway  <= n_eway;
        r_eop   <= n_eop;
        r_okind <= n_okind;
        r_odata <= n_odata;
        r_oop   <= n_oop;
        r_owi   <= n_owi;
        r_olast <= n_olast;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {1'b0, r_owi, r_oop, r_odata};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

`ifndef SYNTH
    a_fill_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fbusy |-> r_fcnt == '0)
        else $error("fill count nonzero without a pending fill");

    a_accept_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_TAG)
        else $error("accepted item did not go to tag lookup");

    a_busy_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == mesic_pkg::KIND_BUSY) |-> r_fbusy)
        else $error("busy result without a pending fill");
`endif
endmodule
`default_nettype wire

>>> dv/two_way_mesi_snooping_cache_tb.sv
// ----------------------------------------------------------------------------
// two_way_mesi_snooping_cache_tb
// Drives CPU accesses, line fills and snoops into the MESI cache and checks
// every result item against a behavioral model of the tag and line stores.
// ----------------------------------------------------------------------------
module two_way_mesi_snooping_cache_tb;

    localparam logic [2:0] CMD_SPARE = 3'd6;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] data_out;
        logic [2:0]  bus_op;
        logic [3:0]  word_index;
        logic        last;
    } t_result;

    class cache_scoreboard;
        logic [1:0]  line_st [2][16];
        logic [23:0] line_tag [2][16];
        logic [31:0] words [2][16][16];
        bit          lru;
        bit          filling;
        int          fill_cnt;
        logic [31:0] fill_addr;
        bit          fill_shr;
        t_result     pending[$];
        int          errors;

        function new();
            for (int w = 0; w < 2; w++)
                for (int s = 0; s < 16; s++) begin
                    line_st[w][s] = mesic_pkg::ST_I;
                    line_tag[w][s] = '0;
                    for (int o = 0; o < 16; o++) words[w][s][o] = '0;
                end
            lru = 0;
            filling = 0;
            fill_cnt = 0;
            fill_addr = '0;
            fill_shr = 0;
            errors = 0;
        endfunction

        function void push(logic [2:0] k, logic [31:0] d, logic [2:0] op, logic [3:0] wi,
                           logic l);
            t_result r;
            r.kind = k;
            r.data_out = d;
            r.bus_op = op;
            r.word_index = wi;
            r.last = l;
            pending = {pending, r};
        endfunction

        function void push_line(int w, int s, logic [2:0] op);
            for (int i = 0; i < 16; i++)
                push(mesic_pkg::KIND_SWORD, words[w][s][i], op, i[3:0], i == 15);
        endfunction

        function void note_item(logic [2:0] cmd, logic [31:0] a, logic [31:0] d, logic fc);
            int s, off, w, way, fs, pos;
            logic [23:0] tg;
            logic [2:0] op;
            s = a[7:4];
            off = a[3:0];
            tg = a[31:8];
            w = -1;
            for (int i = 1; i >= 0; i--)
                if (line_st[i][s] != mesic_pkg::ST_I && line_tag[i][s] == tg) w = i;
            case (cmd)
                mesic_pkg::CMD_READ, mesic_pkg::CMD_WRITE: begin
                    if (filling) begin
                        push(mesic_pkg::KIND_BUSY, '0, mesic_pkg::OP_NONE, '0, 1'b1);
                    end else if (cmd == mesic_pkg::CMD_READ) begin
                        if (w >= 0) begin
                            lru = w[0];
                            push(mesic_pkg::KIND_READ, words[w][s][off], mesic_pkg::OP_NONE,
                                 off[3:0], 1'b1);
                        end else begin
                            line_st[!lru][s] = mesic_pkg::ST_I;
                            line_tag[!lru][s] = '0;
                            filling = 1;
                            fill_cnt = 0;
                            fill_addr = a;
                            fill_shr = 0;
                            push(mesic_pkg::KIND_MISS, '0, mesic_pkg::OP_READ, '0, 1'b1);
                        end
                    end else begin
                        op = mesic_pkg::OP_NONE;
                        if (w >= 0) begin
                            way = w;
                            if (line_st[way][s] == mesic_pkg::ST_S) op = mesic_pkg::OP_INV;
                        end else begin
                            way = !lru;
                            op = mesic_pkg::OP_RWITM;
                        end
                        line_st[way][s] = mesic_pkg::ST_M;
                        line_tag[way][s] = tg;
                        words[way][s][off] = d;
                        lru = way[0];
                        push(mesic_pkg::KIND_WDONE, '0, op, off[3:0], 1'b1);
                    end
                end
                mesic_pkg::CMD_FILL: begin
                    if (filling) begin
                        way = !lru;
                        fs = fill_addr[7:4];
                        pos = fill_cnt;
                        words[way][fs][pos] = d;
                        if (fc) fill_shr = 1;
                        fill_cnt++;
                        if (fill_cnt >= 16) begin
                            line_st[way][fs] = fill_shr ? mesic_pkg::ST_S : mesic_pkg::ST_E;
                            line_tag[way][fs] = fill_addr[31:8];
                            lru = way[0];
                            filling = 0;
                            fill_cnt = 0;
                            fill_shr = 0;
                            push(mesic_pkg::KIND_FILL, words[way][fs][fill_addr[3:0]],
                                 mesic_pkg::OP_NONE, fill_addr[3:0], 1'b1);
                        end else begin
                            push(mesic_pkg::KIND_FILL, d, mesic_pkg::OP_NONE, pos[3:0], 1'b1);
                        end
                    end
                end
                mesic_pkg::CMD_SREAD: begin
                    if (w < 0) begin
                        push(mesic_pkg::KIND_SMISS, '0, mesic_pkg::OP_NONE, '0, 1'b1);
                    end else begin
                        push_line(w, s, line_st[w][s] == mesic_pkg::ST_M ? mesic_pkg::OP_WB
                                                                         : mesic_pkg::OP_NONE);
                        line_st[w][s] = mesic_pkg::ST_S;
                    end
                end
                mesic_pkg::CMD_SINV: begin
                    if (w >= 0 && line_st[w][s] == mesic_pkg::ST_S)
                        line_st[w][s] = mesic_pkg::ST_I;
                    push(mesic_pkg::KIND_SMISS, '0, mesic_pkg::OP_NONE, '0, 1'b1);
                end
                mesic_pkg::CMD_SRWIM: begin
                    if (w >= 0 && line_st[w][s] == mesic_pkg::ST_M) begin
                        line_st[w][s] = mesic_pkg::ST_I;
                        push_line(w, s, mesic_pkg::OP_WB);
                    end else begin
                        if (w >= 0) line_st[w][s] = mesic_pkg::ST_I;
                        push(mesic_pkg::KIND_SMISS, '0, mesic_pkg::OP_NONE, '0, 1'b1);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                $display("%0t: mismatch expected kind=%0d data=%h op=%0d wi=%0d last=%0d",
                         $time, exp_r.kind, exp_r.data_out, exp_r.bus_op,
                         exp_r.word_index, exp_r.last);
                $display("%0t:          actual   kind=%0d data=%h op=%0d wi=%0d last=%0d",
                         $time, got.kind, got.data_out, got.bus_op,
                         got.word_index, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic [3:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [39:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    two_way_mesi_snooping_cache dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    cache_scoreboard sb = new();
    int src_idle = 17;
    int dst_idle = 53;
    bit hold_off = 0;
    logic [31:0] hot_addr [4];

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result({o_m_tuser, o_m_tdata[31:0], o_m_tdata[34:32],
                             o_m_tdata[38:35], o_m_tlast});
        i_m_tready <= !hold_off && ($urandom_range(99) >= dst_idle);
    end

    task automatic quiet();
        i_s_tvalid <= 0;
        @(posedge i_clk);
    endtask

    task automatic send(logic [2:0] cmd, logic [31:0] a, logic [31:0] d, logic fc);
        while ($urandom_range(99) < src_idle) quiet();
        i_s_tvalid <= 1;
        i_s_tdata <= {d, a};
        i_s_tuser <= {fc, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(cmd, a, d, fc);
    endtask

    task automatic fill_line(bit ragged);
        for (int i = 0; i < 16; i++) begin
            send(mesic_pkg::CMD_FILL, $urandom, $urandom,
                 ragged ? 1'($urandom_range(1)) : 1'b0);
            if (ragged && $urandom_range(9) == 0)
                send($urandom_range(1) ? mesic_pkg::CMD_READ : mesic_pkg::CMD_SREAD,
                     hot_addr[$urandom_range(3)], $urandom, 1'b0);
        end
    endtask

    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = hot_addr[$urandom_range(3)];
        if ($urandom_range(3) == 0) a = $urandom;
        a[3:0] = 4'($urandom);
        return a;
    endfunction

    task automatic random_phase(int n);
        logic [31:0] a;
        for (int k = 0; k < n; k++) begin
            a = pick_addr();
            case ($urandom_range(9))
                0, 1: begin
                    send(mesic_pkg::CMD_READ, a, $urandom, 1'($urandom_range(1)));
                    if (sb.filling && $urandom_range(4) != 0)
                        fill_line($urandom_range(1));
                end
                2, 3, 4: send(mesic_pkg::CMD_WRITE, a, $urandom, 1'($urandom_range(1)));
                5: send(mesic_pkg::CMD_SREAD, a, $urandom, 1'b0);
                6: send(mesic_pkg::CMD_SINV, a, $urandom, 1'b0);
                7: send(mesic_pkg::CMD_SRWIM, a, $urandom, 1'b0);
                8: send(mesic_pkg::CMD_FILL, a, $urandom, 1'($urandom_range(1)));
                default: send(3'(CMD_SPARE + $urandom_range(1)), a, $urandom, 1'b1);
            endcase
        end
        if (sb.filling) fill_line(0);
        quiet();
    endtask

    initial begin
        for (int i = 0; i < 4; i++) begin
            hot_addr[i] = $urandom;
            hot_addr[i][7:4] = i[0] ? 4'hF : 4'h0;
        end
        hot_addr[1][31:8] = hot_addr[0][31:8] ^ 24'h1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: field extremes, misses, fills, write paths, every snoop
        send(mesic_pkg::CMD_FILL, 32'h0, 32'hFFFFFFFF, 1'b1);
        send(mesic_pkg::CMD_SREAD, 32'hFFFFFFFF, '0, 1'b0);
        send(mesic_pkg::CMD_READ, 32'h0000_0005, '0, 1'b0);
        send(mesic_pkg::CMD_WRITE, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0);
        for (int i = 0; i < 16; i++)
            send(mesic_pkg::CMD_FILL, 32'hFFFFFFFF, i[0] ? 32'hFFFFFFFF : 32'h0, 1'b0);
        send(mesic_pkg::CMD_READ, 32'h0000_0005, '0, 1'b0);
        send(mesic_pkg::CMD_SREAD, 32'h0000_0003, '0, 1'b0);
        send(mesic_pkg::CMD_WRITE, 32'h0000_0007, 32'hFFFFFFFF, 1'b0);
        send(mesic_pkg::CMD_WRITE, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
        send(mesic_pkg::CMD_SRWIM, 32'hFFFF_FFF0, '0, 1'b0);
        send(mesic_pkg::CMD_SREAD, 32'h0000_0000, '0, 1'b0);
        send(mesic_pkg::CMD_SINV, 32'h0000_0000, '0, 1'b0);
        send(mesic_pkg::CMD_SRWIM, 32'h0000_0000, '0, 1'b0);
        send(mesic_pkg::CMD_WRITE, 32'h0000_0100, 32'h0, 1'b0);
        send(mesic_pkg::CMD_SRWIM, 32'h0000_0100, '0, 1'b0);
        send(mesic_pkg::CMD_READ, 32'hFFFF_FF0F, '0, 1'b0);
        send(mesic_pkg::CMD_WRITE, 32'h0, '0, 1'b0);
        send(mesic_pkg::CMD_SINV, 32'h0, '0, 1'b0);
        for (int i = 0; i < 16; i++) send(mesic_pkg::CMD_FILL, 32'h0, ~i, i == 9);
        send(CMD_SPARE | 3'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);

        random_phase(8);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(4);
        join
        src_idle = 53; dst_idle = 17;
        random_phase(5);
        src_idle = 0; dst_idle = 0;
        random_phase(5);

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("two_way_mesi_snooping_cache_tb: done, clean");
        else
            $display("two_way_mesi_snooping_cache_tb: done, errors");
        $finish;
    end

    initial begin
        #4000000;
        $display("two_way_mesi_snooping_cache_tb: done, errors");
        $finish;
    end
endmodule
